>>> src/hrcp_pkg.sv
// Package for the HTTP response parser: phase codes, result kinds, error codes,
// header name tables and the result word type. No dependencies.
package hrcp_pkg;

   localparam int LENGTH_BITS_DEF = 64;
   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_BITS = 3;
   localparam int RSP_PER_WORD = 3;

   typedef enum logic [2:0] {
      PH_STATUS = 3'd0,
      PH_NAME   = 3'd1,
      PH_VALUE  = 3'd2,
      PH_CHSIZE = 3'd3,
      PH_CHDATA = 3'd4,
      PH_CHSKIP = 3'd5,
      PH_BODY   = 3'd6,
      PH_DEAD   = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      VK_NONE     = 3'd0,
      VK_LOCATION = 3'd1,
      VK_CTYPE    = 3'd2,
      VK_TE       = 3'd3,
      VK_CLEN     = 3'd4
   } vkind_type;

   typedef enum logic [1:0] {
      NS_FIRST   = 2'd0,
      NS_DIGITS  = 2'd1,
      NS_STOPPED = 2'd2,
      NS_FAILED  = 2'd3
   } nstate_type;

   localparam logic [2:0] KIND_BODY       = 3'd0;
   localparam logic [2:0] KIND_LOC_START  = 3'd1;
   localparam logic [2:0] KIND_LOC_BYTE   = 3'd2;
   localparam logic [2:0] KIND_CT_START   = 3'd3;
   localparam logic [2:0] KIND_CT_BYTE    = 3'd4;
   localparam logic [2:0] KIND_SUMMARY    = 3'd5;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_NO_TERM = 2'd1;
   localparam logic [1:0] ERR_NO_STAT = 2'd2;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_C     = 8'h63;

   localparam logic [55:0] CHUNK_WORD = "chunked";

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  out_byte;
      logic [10:0] status_code;
      logic [1:0]  fault_code;
      logic        final_res;
   } rsp_type;

   function automatic logic [4:0] hdr_len(input logic [1:0] i);
      logic [4:0] l;
      case (i)
         2'd0: l = 5'd8;
         2'd1: l = 5'd12;
         2'd2: l = 5'd17;
         2'd3: l = 5'd14;
         default: l = 5'd0;
      endcase
      return l;
   endfunction

   function automatic vkind_type hdr_kind(input logic [1:0] i);
      vkind_type k;
      case (i)
         2'd0: k = VK_LOCATION;
         2'd1: k = VK_CTYPE;
         2'd2: k = VK_TE;
         2'd3: k = VK_CLEN;
         default: k = VK_NONE;
      endcase
      return k;
   endfunction

   // Character of a header name at a position below its length.
   function automatic logic [7:0] hdr_char(input logic [1:0] i, input logic [4:0] p);
      logic [135:0] s;
      logic [4:0]   idx;
      case (i)
         2'd0: s = 136'("location");
         2'd1: s = 136'("content-type");
         2'd2: s = 136'("transfer-encoding");
         2'd3: s = 136'("content-length");
         default: s = '0;
      endcase
      idx = hdr_len(i) - 5'd1 - p;
      return s[8 * idx +: 8];
   endfunction

endpackage

>>> src/http_response_chunked_parser.sv
// Top level of the HTTP response parser with chunked body decoding.
// Depends on hrcp_pkg for codes, header tables and the result word type.
//
// channel  direction  handshake            payload
// req      in         req_valid/req_stall  req_data_byte, req_end_of_stream
// rsp      out        rsp_valid/rsp_stall  kind, out_byte, status_code, fault_code, final_res
// csr      in         csr_valid/csr_ready  csr_max_body_bytes
//
// Each byte is parsed combinationally and its zero to three result words are written into
// an eight-entry result queue, so one byte is taken every cycle while req_stall is low.
// A byte's first word is offered once the words ahead of it drain; the queue drains one
// word per cycle while rsp_stall is low. req_stall rises while fewer than three entries
// are free. Reset is synchronous and returns the parser to the status line.
module http_response_chunked_parser #(
   parameter int LENGTH_BITS = hrcp_pkg::LENGTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic signed [10:0] rsp_status_code,
   output logic [1:0]  rsp_fault_code,
   output logic        rsp_final_res,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_max_body_bytes
);
   import hrcp_pkg::*;

   typedef struct packed {
      phase_type              phase;
      logic [1:0]             term;
      logic                   pcr;
      logic                   head_found;
      logic [9:0]             sval;
      logic [1:0]             sdigits;
      logic                   sneg;
      logic                   sspace;
      logic                   sstop;
      logic                   sany;
      logic [4:0]             npos;
      logic [3:0]             nalive;
      vkind_type              vkind;
      logic                   vstarted;
      logic                   chmode;
      logic [2:0]             chmatch;
      nstate_type             nstate;
      logic [LENGTH_BITS-1:0] nacc;
      logic [LENGTH_BITS-1:0] lenval;
      logic                   lenvalid;
      logic [LENGTH_BITS-1:0] chrem;
      logic [1:0]             skip;
      logic [31:0]            bcount;
   } st_type;

   function automatic st_type clear_st();
      st_type s;
      s = '0;
      s.phase = PH_STATUS;
      s.nalive = 4'hF;
      s.vkind = VK_NONE;
      s.nstate = NS_FIRST;
      return s;
   endfunction

   function automatic void feed(input nstate_type ns, input logic [LENGTH_BITS-1:0] acc,
                                input logic [7:0] c, input logic hex,
                                output nstate_type ns_o, output logic [LENGTH_BITS-1:0] acc_o);
      logic [3:0]             d;
      logic                   ok;
      logic [LENGTH_BITS+3:0] ext;
      ns_o = ns;
      acc_o = acc;
      d = '0;
      ok = 1'b0;
      if (c >= "0" && c <= "9") begin
         d = 4'(c - "0");
         ok = 1'b1;
      end else if (hex && c >= "a" && c <= "f") begin
         d = 4'(c - "a" + 8'd10);
         ok = 1'b1;
      end else if (hex && c >= "A" && c <= "F") begin
         d = 4'(c - "A" + 8'd10);
         ok = 1'b1;
      end
      if (hex) begin
         ext = {acc, 4'b0000} + (LENGTH_BITS+4)'(d);
      end else begin
         ext = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (LENGTH_BITS+4)'(d);
      end
      if (ns == NS_FIRST || ns == NS_DIGITS) begin
         if (!ok) begin
            ns_o = (ns == NS_FIRST) ? NS_FAILED : NS_STOPPED;
         end else if (ext[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
            ns_o = NS_FAILED;
         end else begin
            acc_o = ext[LENGTH_BITS-1:0];
            ns_o = NS_DIGITS;
         end
      end
   endfunction

   function automatic st_type start_hex(input st_type s);
      st_type r;
      r = s;
      r.phase = PH_CHSIZE;
      r.nstate = NS_FIRST;
      r.chrem = '0;
      r.pcr = 1'b0;
      return r;
   endfunction

   function automatic st_type new_header(input st_type s);
      st_type r;
      r = s;
      r.phase = PH_NAME;
      r.npos = '0;
      r.nalive = 4'hF;
      r.vkind = VK_NONE;
      return r;
   endfunction

   function automatic logic status_zero(input st_type s);
      return !s.sany || s.sval == 10'd0;
   endfunction

   function automatic st_type content_f(input st_type s, input logic [7:0] c,
                                        output logic ev, output logic [2:0] ek,
                                        output logic [7:0] eb);
      st_type     r;
      logic [7:0] low;
      r = s;
      ev = 1'b0;
      ek = KIND_BODY;
      eb = '0;
      low = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      if (s.phase == PH_CHSIZE) begin
         feed(s.nstate, s.chrem, c, 1'b1, r.nstate, r.chrem);
      end else begin
         r.term = '0;
         case (s.phase)
            PH_STATUS: begin
               if (!s.sspace) begin
                  if (c == CH_SP) r.sspace = 1'b1;
               end else if (!s.sstop && s.sdigits != 2'd3) begin
                  if (s.sdigits == 2'd0 && c == CH_MINUS) begin
                     r.sneg = 1'b1;
                  end else if (c >= "0" && c <= "9") begin
                     r.sval = 10'(s.sval * 10'd10 + 10'(c - "0"));
                     r.sany = 1'b1;
                  end else begin
                     r.sstop = 1'b1;
                  end
                  r.sdigits = s.sdigits + 2'd1;
               end
            end
            PH_NAME: begin
               if (c == CH_COLON) begin
                  r.vkind = VK_NONE;
                  for (int i = 0; i < 4; i++) begin
                     if (s.nalive[i] && s.npos == hdr_len(2'(i))) r.vkind = hdr_kind(2'(i));
                  end
                  r.phase = PH_VALUE;
                  r.vstarted = 1'b0;
                  r.chmatch = '0;
                  r.nstate = NS_FIRST;
                  r.nacc = '0;
                  if (r.vkind == VK_LOCATION) begin
                     ev = 1'b1;
                     ek = KIND_LOC_START;
                  end else if (r.vkind == VK_CTYPE) begin
                     ev = 1'b1;
                     ek = KIND_CT_START;
                  end
               end else begin
                  for (int i = 0; i < 4; i++) begin
                     if (s.nalive[i] && (s.npos >= hdr_len(2'(i)) ||
                                         hdr_char(2'(i), s.npos) != low)) begin
                        r.nalive[i] = 1'b0;
                     end
                  end
                  if (s.npos != 5'd31) r.npos = s.npos + 5'd1;
               end
            end
            PH_VALUE: begin
               if (s.vstarted || (c != CH_SP && c != CH_TAB)) begin
                  r.vstarted = 1'b1;
                  case (s.vkind)
                     VK_LOCATION: begin
                        ev = 1'b1;
                        ek = KIND_LOC_BYTE;
                        eb = c;
                     end
                     VK_CTYPE: begin
                        ev = 1'b1;
                        ek = KIND_CT_BYTE;
                        eb = c;
                     end
                     VK_TE: begin
                        if (s.chmatch != 3'd7) begin
                           if (c == CHUNK_WORD[8 * (3'd6 - s.chmatch) +: 8]) begin
                              r.chmatch = s.chmatch + 3'd1;
                           end else begin
                              r.chmatch = (c == CH_C) ? 3'd1 : 3'd0;
                           end
                        end
                     end
                     VK_CLEN: feed(s.nstate, s.nacc, c, 1'b0, r.nstate, r.nacc);
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end
      return r;
   endfunction

   function automatic st_type line_close(input st_type s);
      st_type r;
      r = s;
      if (s.phase == PH_CHSIZE) begin
         r.phase = ((s.nstate == NS_DIGITS || s.nstate == NS_STOPPED) && s.chrem != '0) ?
                   PH_CHDATA : PH_DEAD;
      end else begin
         if (s.term != 2'd2) r.term = s.term + 2'd1;
         if (r.term == 2'd2) begin
            r.head_found = 1'b1;
            r.pcr = 1'b0;
            if (s.phase != PH_DEAD) begin
               if (s.chmode) begin
                  r = start_hex(r);
               end else begin
                  r.phase = PH_BODY;
                  r.chrem = s.lenval;
               end
            end
         end else begin
            case (s.phase)
               PH_STATUS: begin
                  if (status_zero(s)) r.phase = PH_DEAD;
                  else r = new_header(r);
               end
               PH_NAME: r = new_header(r);
               PH_VALUE: begin
                  if (s.vkind == VK_TE) begin
                     r.chmode = (s.chmatch == 3'd7);
                  end else if (s.vkind == VK_CLEN &&
                               (s.nstate == NS_DIGITS || s.nstate == NS_STOPPED)) begin
                     r.lenval = s.nacc;
                     r.lenvalid = 1'b1;
                  end
                  r = new_header(r);
               end
               default: ;
            endcase
         end
      end
      return r;
   endfunction

   function automatic st_type body_f(input st_type s, input logic [31:0] maxb,
                                     output logic ev);
      st_type r;
      logic   want;
      r = s;
      want = 1'b0;
      case (s.phase)
         PH_CHDATA: begin
            want = 1'b1;
            if (s.chrem != '0) r.chrem = s.chrem - 1'b1;
            if (r.chrem == '0) begin
               r.phase = PH_CHSKIP;
               r.skip = 2'd2;
            end
         end
         PH_CHSKIP: begin
            if (s.skip != 2'd0) r.skip = s.skip - 2'd1;
            if (r.skip == 2'd0) r = start_hex(r);
         end
         PH_BODY: begin
            if (!s.lenvalid) begin
               want = 1'b1;
            end else if (s.chrem != '0) begin
               want = 1'b1;
               r.chrem = s.chrem - 1'b1;
            end
         end
         default: ;
      endcase
      ev = want && (s.bcount < maxb);
      if (ev) r.bcount = s.bcount + 32'd1;
      return r;
   endfunction

   st_type             st_ff, st_in;
   logic [31:0]        maxb_ff, maxb_in;
   rsp_type            fifo_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [RSP_PTR_BITS:0]   cnt_ff, cnt_in;

   rsp_type    res [RSP_PER_WORD];
   logic [1:0] nres;
   logic       accept, pop;

   assign accept = req_valid && !req_stall;
   assign pop = rsp_valid && !rsp_stall;
   assign req_stall = cnt_ff > (RSP_PTR_BITS+1)'(RSP_DEPTH - RSP_PER_WORD);
   assign csr_ready = 1'b1;
   assign maxb_in = (csr_valid && csr_ready) ? csr_max_body_bytes : maxb_ff;

   always_comb begin
      st_type       s;
      logic         lined, e0, e1;
      logic [2:0]   k0, k1;
      logic [7:0]   b0, b1, b;
      rsp_type      cand [RSP_PER_WORD];
      logic [2:0]   cv;
      logic [10:0]  sv;
      s = st_ff;
      b = req_data_byte;
      e0 = 1'b0;
      e1 = 1'b0;
      k0 = KIND_BODY;
      k1 = KIND_BODY;
      b0 = '0;
      b1 = '0;
      lined = st_ff.phase <= PH_CHSIZE || (st_ff.phase == PH_DEAD && !st_ff.head_found);
      if (lined) begin
         if (st_ff.pcr) begin
            s.pcr = 1'b0;
            if (b == CH_LF) begin
               s = line_close(s);
            end else begin
               s = content_f(s, CH_CR, e0, k0, b0);
               if (b == CH_CR) s.pcr = 1'b1;
               else s = content_f(s, b, e1, k1, b1);
            end
         end else if (b == CH_CR) begin
            s.pcr = 1'b1;
         end else begin
            s = content_f(s, b, e0, k0, b0);
         end
      end else begin
         s = body_f(s, maxb_ff, e0);
         b0 = b;
         k0 = KIND_BODY;
      end
      sv = {1'b0, s.sval};
      if (!s.sany) sv = '0;
      else if (s.sneg) sv = -sv;
      cand[0] = '{kind: k0, out_byte: b0, status_code: '0, fault_code: ERR_NONE,
                  final_res: 1'b0};
      cand[1] = '{kind: k1, out_byte: b1, status_code: '0, fault_code: ERR_NONE,
                  final_res: 1'b0};
      cand[2] = '{kind: KIND_SUMMARY, out_byte: '0, status_code: '0,
                  fault_code: ERR_NONE, final_res: 1'b0};
      if (!s.head_found) cand[2].fault_code = ERR_NO_TERM;
      else if (sv == 11'd0) cand[2].fault_code = ERR_NO_STAT;
      else cand[2].status_code = sv;
      cv = {req_end_of_stream, e1, e0};
      for (int i = 0; i < RSP_PER_WORD; i++) res[i] = cand[0];
      nres = '0;
      for (int i = 0; i < RSP_PER_WORD; i++) begin
         if (cv[i]) begin
            res[nres] = cand[i];
            nres = nres + 2'd1;
         end
      end
      if (nres != 2'd0) res[nres - 2'd1].final_res = 1'b1;
      if (req_end_of_stream) s = clear_st();
      st_in = accept ? s : st_ff;
   end

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         wr_in = wr_ff + RSP_PTR_BITS'(nres);
         cnt_in = cnt_in + (RSP_PTR_BITS+1)'(nres);
      end
      if (pop) begin
         rd_in = rd_ff + 1'b1;
         cnt_in = cnt_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= clear_st();
         maxb_ff <= 32'd16777216;
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         maxb_ff <= maxb_in;
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < RSP_PER_WORD; i++) begin
            if (2'(i) < nres) fifo_ff[wr_ff + RSP_PTR_BITS'(i)] <= res[i];
         end
      end
   end

   assign rsp_valid = cnt_ff != '0;
   assign rsp_kind = fifo_ff[rd_ff].kind;
   assign rsp_out_byte = fifo_ff[rd_ff].out_byte;
   assign rsp_status_code = fifo_ff[rd_ff].status_code;
   assign rsp_fault_code = fifo_ff[rd_ff].fault_code;
   assign rsp_final_res = fifo_ff[rd_ff].final_res;

endmodule
